// File: rtl/core/sidc_pkg.sv
// Shared constants and helpers for the signed integer to decimal text converter.
// Holds the ASCII codes, the power-of-ten table and the digit count helper.
// No dependencies.
package sidc_pkg;

  localparam int VALUE_BITS_DEF = 32;

  localparam logic [5:0] CH_MINUS = 6'd45;
  localparam logic [5:0] CH_ZERO  = 6'd48;
  localparam logic [5:0] CH_NINE  = 6'd57;

  // Powers of ten up to 10^19, enough for any 64-bit magnitude.
  function automatic logic [63:0] pow10(input logic [4:0] p);
    logic [63:0] r;
    case (p)
      5'd0:    r = 64'd1;
      5'd1:    r = 64'd10;
      5'd2:    r = 64'd100;
      5'd3:    r = 64'd1000;
      5'd4:    r = 64'd10000;
      5'd5:    r = 64'd100000;
      5'd6:    r = 64'd1000000;
      5'd7:    r = 64'd10000000;
      5'd8:    r = 64'd100000000;
      5'd9:    r = 64'd1000000000;
      5'd10:   r = 64'd10000000000;
      5'd11:   r = 64'd100000000000;
      5'd12:   r = 64'd1000000000000;
      5'd13:   r = 64'd10000000000000;
      5'd14:   r = 64'd100000000000000;
      5'd15:   r = 64'd1000000000000000;
      5'd16:   r = 64'd10000000000000000;
      5'd17:   r = 64'd100000000000000000;
      5'd18:   r = 64'd1000000000000000000;
      5'd19:   r = 64'd10000000000000000000;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

  // Number of decimal digits of 2^(bits-1), the largest magnitude.
  function automatic int digit_count(input int bits);
    logic [63:0] v;
    int          n;
    v = 64'd1 << (bits - 1);
    n = 1;
    for (int i = 1; i < 20; i++) begin
      if (pow10(5'(i)) <= v) n = i + 1;
    end
    return n;
  endfunction

endpackage

// File: rtl/core/sidc_front.sv
// Front end: takes the input request and splits it into sign and magnitude.
// Feeds the item queue. No package dependency; plain logic only.
module sidc_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [VALUE_BITS:0]   push_data
);

  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  // Magnitude fits unsigned in VALUE_BITS, most negative value included.
  assign neg        = value[VALUE_BITS-1];
  assign mag        = neg ? (~value + VALUE_BITS'(1)) : value;
  assign push_data  = {neg, mag};
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// File: rtl/core/sidc_queue.sv
// Two-entry queue between the front and the digit unit.
// Flop storage; no package dependency.
module sidc_queue #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/core/sidc_back.sv
// Back end: emits the sign, then one decimal position per cycle from the top
// when not stalled. Depends on sidc_pkg: power-of-ten table, character codes.
module sidc_back #(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [VALUE_BITS:0]   q_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [5:0]            out_code,
  output logic                  out_last
);

  localparam int PW = $clog2(NDIG);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SIGN  = 2'd1;
  localparam logic [1:0] ST_DIGIT = 2'd2;

  logic [1:0]            state;
  logic [VALUE_BITS-1:0] rem;
  logic [PW-1:0]         pos;
  logic                  started;

  logic [63:0]           pw;
  logic [67:0]           rem_w;
  logic [67:0]           sub;
  logic [3:0]            dig;
  logic                  emit;
  logic                  slot_free;
  logic                  load_out;

  assign q_ready   = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign load_out  = slot_free && ((state == ST_SIGN) || ((state == ST_DIGIT) && emit));

  // Pick the largest multiple of the current power that fits the remainder.
  always_comb begin
    pw    = sidc_pkg::pow10(5'(pos));
    rem_w = 68'(rem);
    dig   = 4'd0;
    sub   = 68'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem_w >= 68'(k) * {4'b0000, pw}) begin
        dig = 4'(k);
        sub = 68'(k) * {4'b0000, pw};
      end
    end
    emit = started || (dig != 4'd0) || (pos == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      if (load_out)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            rem     <= q_data[VALUE_BITS-1:0];
            pos     <= PW'(NDIG - 1);
            started <= 1'b0;
            state   <= q_data[VALUE_BITS] ? ST_SIGN : ST_DIGIT;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            out_code  <= sidc_pkg::CH_MINUS;
            out_last  <= 1'b0;
            state     <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (!emit || slot_free) begin
            rem <= rem - sub[VALUE_BITS-1:0];
            if (emit) begin
              out_code  <= sidc_pkg::CH_ZERO + 6'(dig);
              out_last  <= (pos == '0);
              started   <= 1'b1;
            end
            if (pos == '0) state <= ST_IDLE;
            else           pos   <= pos - PW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/signed_int_to_decimal_chars.sv
// A minus sign, or the top digit of a full-length number, comes out of the back end's
//   output register once the request has passed the queue and been loaded; leading zero
//   positions are walked first without output. Per item: a load step, one cycle per
//   decimal position (10 at 32 bits) unless stalled, and a step for a minus sign.
// A two-entry queue lets the next request be taken while a conversion runs.
// Reset (rst, synchronous): empties the queue, idles the digit unit, drops output.
module signed_int_to_decimal_chars #(
  parameter int VALUE_BITS = sidc_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: value [VALUE_BITS-1:0], zero fill up to a whole byte
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: char_code [5:0], zeros [7:6]
  output logic [7:0]                          m_tdata,
  output logic                                m_tlast
);

  // Most digits of any magnitude at this width.
  localparam int NDIG = sidc_pkg::digit_count(VALUE_BITS);

  logic                push_valid;
  logic                push_ready;
  logic [VALUE_BITS:0] push_data;
  logic                pop_valid;
  logic                pop_ready;
  logic [VALUE_BITS:0] pop_data;
  logic [5:0]          out_code;

  // Front: split sign and magnitude of the incoming request.
  sidc_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .value     (s_tdata[VALUE_BITS-1:0]),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  // Queue: hold up to two classified requests while the back end works.
  sidc_queue #(
    .WIDTH(VALUE_BITS + 1)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  // Back: emit sign and digits, one registered character at a time.
  sidc_back #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (pop_valid),
    .q_ready  (pop_ready),
    .q_data   (pop_data),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_code (out_code),
    .out_last (m_tlast)
  );

  assign m_tdata = {2'b00, out_code};

  // Every character is a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_code == sidc_pkg::CH_MINUS) ||
                 ((out_code >= sidc_pkg::CH_ZERO) && (out_code <= sidc_pkg::CH_NINE)))
    else $error("character code out of range");

  // A minus sign never ends a run.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_code == sidc_pkg::CH_MINUS)) |-> !m_tlast)
    else $error("minus sign flagged as last character");

  // A minus sign is always followed by a digit, never by another sign.
  a_sign_then_digit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && (out_code == sidc_pkg::CH_MINUS)) |=>
      !(m_tvalid && (out_code == sidc_pkg::CH_MINUS)))
    else $error("two minus signs in a row");

endmodule

// File: tb/testbench.sv
// Self-checking bench for signed_int_to_decimal_chars: drives signed 32-bit values on
// the request stream and checks every character and last flag on the result stream.
// Depends on sidc_pkg (character codes) and the converter RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VBITS        = 32;
  localparam int RANDOM_ITEMS = 150;
  localparam int TAIL_CYCLES  = 30;

  // One expected output character.
  typedef struct packed {
    logic [5:0] code;
    logic       last;
  } char_t;

  // Directed row: text is the expected string, right aligned; all zeros means
  // the row goes through the predictor instead.
  typedef struct packed {
    logic [VBITS-1:0] value;
    logic [87:0]      text;
  } row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  // s_tdata: value [31:0]
  logic [VBITS-1:0] s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // m_tdata: char_code [5:0], zeros [7:6]
  logic [7:0]       m_tdata;
  logic             m_tlast;

  char_t       pending_chars[$];  // characters still owed by the block
  logic [87:0] queued_text[$];    // typed text of requests driven but not yet taken
  int          errors     = 0;
  int          stall_left = 0;
  bit          calm       = 1'b0; // no new idling on either side while set

  row_t directed_rows [22] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{32'hFFFF_FFFF,  "-1"},
    '{32'd9,          "9"},
    '{32'hFFFF_FFF7,  "-9"},
    '{32'd10,         "10"},
    '{32'hFFFF_FFF6,  "-10"},
    '{32'h7FFF_FFFF,  "2147483647"},
    '{32'h8000_0000,  "-2147483648"},  // most negative: magnitude needs all 32 bits
    '{32'h8000_0001,  "-2147483647"},
    '{32'd1000000000, "1000000000"},   // trailing zeros all written
    '{32'hC465_3600,  "-1000000000"},
    '{32'd999999999,  '0},
    '{32'd100,        '0},
    '{32'hFFFE_7960,  '0},
    '{32'd12345,      '0},
    '{32'hFFFF_FFF9,  '0},
    '{32'h5555_5555,  '0},
    '{32'hAAAA_AAAA,  '0},
    '{32'h0000_FFFF,  '0},
    '{32'd2000000000, '0},
    '{32'h88CA_6C0A,  '0}
  };

  signed_int_to_decimal_chars #(.VALUE_BITS(VBITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("mismatch at %0t ns: %s", $realtime, what);
  endtask

  // Expand a value into its decimal characters: sign first, then the digits
  // from the most significant down, last flag on the final digit.
  function automatic void predict_decimal(input logic [VBITS-1:0] v);
    logic        neg;
    logic [VBITS:0] mag;
    logic [3:0]  digs [12];
    int          n;
    neg = v[VBITS-1];
    mag = neg ? {1'b0, ~v + 32'd1} : {1'b0, v};
    n = 0;
    do begin
      digs[n] = 4'(mag % 33'd10);
      mag = mag / 33'd10;
      n++;
    end while (mag != 0);
    if (neg) pending_chars.push_back('{sidc_pkg::CH_MINUS, 1'b0});
    for (int i = n - 1; i >= 0; i--) begin
      pending_chars.push_back('{sidc_pkg::CH_ZERO + 6'(digs[i]), i == 0});
    end
  endfunction

  // Queue the typed characters of a directed row, skipping the zero padding.
  function automatic void queue_text(input logic [87:0] text);
    for (int i = 10; i >= 0; i--) begin
      if (text[i*8 +: 8] != 8'd0) pending_chars.push_back('{text[i*8 +: 6], i == 0});
    end
  endfunction

  // Sample both streams at the rising edge: queue expectations for a taken
  // request first, then check a delivered character against the oldest one.
  always @(posedge clk) begin
    logic [87:0] text;
    char_t       want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        text = queued_text.pop_front();
        if (text == '0) predict_decimal(s_tdata);
        else queue_text(text);
      end
      if (m_tvalid && m_tready) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with nothing expected", m_tdata));
        end else begin
          want = pending_chars.pop_front();
          if (m_tdata[5:0] !== want.code)
            report_mismatch($sformatf("char_code %0d, expected %0d", m_tdata[5:0], want.code));
          if (m_tdata[7:6] !== 2'b00)
            report_mismatch($sformatf("fill bits %b, expected 00", m_tdata[7:6]));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last flag %b, expected %b on char %0d",
                                      m_tlast, want.last, want.code));
        end
      end
    end
  end

  // Receiver: stall now and then; about one stall in ten is a long one.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 39) : $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Hold the request high until taken, after the idle gap from pick_gap.
  // Called and returns at a falling edge.
  task automatic send_value(input logic [VBITS-1:0] v, input logic [87:0] text);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    queued_text.push_back(text);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Value mix that exercises digit counts, trailing zeros and decade edges.
  function automatic logic [VBITS-1:0] random_value();
    logic [63:0] p;
    logic [63:0] v;
    int          k;
    bit          may_negate;
    p = 64'd1;
    k = $urandom_range(0, 9);
    for (int i = 0; i < k; i++) p = p * 64'd10;
    may_negate = 1'b1;
    case ($urandom_range(0, 5))
      0: begin
        v = {32'd0, $urandom()};
        may_negate = 1'b0;
      end
      1: v = $urandom_range(0, 99);
      2: begin
        v = p * $urandom_range(1, 9);
        if (v > 64'd2147483647) v = p;
      end
      3: v = p + $urandom_range(0, 2) - 64'd1;
      4: begin
        v = $urandom_range(0, 1) ? 64'h8000_0000 + $urandom_range(0, 3)
                                 : 64'h7FFF_FFFF - $urandom_range(0, 3);
        may_negate = 1'b0;
      end
      default: v = $urandom_range(0, 1000000);
    endcase
    if (may_negate && $urandom_range(0, 1)) v = -v;
    return v[VBITS-1:0];
  endfunction

  // Let the block drain; give up when the bound runs out.
  task automatic wait_drained(input int bound);
    int waited;
    waited = 0;
    while ((pending_chars.size() != 0 || queued_text.size() != 0) && waited < bound) begin
      @(negedge clk);
      waited++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows: extremes, sign handling, zero, trailing zeros.
    foreach (directed_rows[i]) send_value(directed_rows[i].value, directed_rows[i].text);

    // Pause the sender until everything owed has come back.
    s_tvalid <= 1'b0;
    wait_drained(100000);

    // Random part, in stretches of 25 with every third stretch free of idling.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 25 == 0) calm = ((i / 25) % 3 == 2);
      send_value(random_value(), '0);
      if (i == 75) begin
        s_tvalid <= 1'b0;
        wait_drained(100000);
      end
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    wait_drained(20000);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_chars.size() != 0)
      report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
